// File: src/tap_tempo_beat_clock_core_assert.svh
// ----------------------------------------------------------------------------
// Tap tempo beat clock assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_BEAT_CLOCK_CORE_ASSERT_SVH
`define TAP_TEMPO_BEAT_CLOCK_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ttbc_pkg.sv
// ----------------------------------------------------------------------------
// Tap tempo beat clock package
// Widths, reset values, codes and helpers shared by the beat clock modules.
// ----------------------------------------------------------------------------
package ttbc_pkg;

  localparam int unsigned SrW      = 18;
  localparam int unsigned BufW     = 14;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned TapOffW  = 13;
  localparam int unsigned TotInW   = 11;
  localparam int unsigned BarW     = 7;
  localparam int unsigned TempoW   = 10;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned OffW     = 13;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned SpbW     = 24;
  localparam int unsigned DivW     = 32;
  localparam int unsigned TapCntW  = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 18;
  localparam int unsigned ProdW    = TempoW + BarW;

  // Reciprocal scaling for the division of a tapped rate by one hundred.
  localparam int unsigned CentiW      = 17;
  localparam int unsigned RecipW      = 18;
  localparam int unsigned RecipProdW  = CentiW + RecipW;
  localparam int unsigned RECIP_SHIFT = 24;

  localparam int unsigned MAX_LOOP_BEATS_DEF = 1024;

  localparam logic [SrW-1:0]     SR_RESET    = SrW'(48000);
  localparam logic [BufW-1:0]    BUF_RESET   = BufW'(256);
  localparam logic [TempoW-1:0]  TEMPO_RESET = TempoW'(120);
  localparam logic [BarW-1:0]    BAR_RESET   = BarW'(4);
  localparam logic [SpbW-1:0]    SPB_RESET   = SpbW'(24000);
  localparam logic [TempoW-1:0]  TEMPO_MIN   = TempoW'(1);
  localparam logic [TempoW-1:0]  TEMPO_MAX   = TempoW'(999);
  localparam logic [TapCntW-1:0] TAP_LAST    = TapCntW'(5);

  localparam logic [DivW-1:0] SEC_PER_MIN       = DivW'(60);
  localparam logic [DivW-1:0] CENTI_SEC_PER_MIN = DivW'(6000);
  localparam logic [DivW-1:0] TEMPO_SCALE       = DivW'(100);
  // Smallest scaled rate whose hundredth exceeds the top tempo.
  localparam logic [DivW-1:0] CENTI_TOP         = DivW'(100000);
  // 2^24 / 100 rounded up; exact for every scaled rate below CENTI_TOP.
  localparam logic [RecipW-1:0] RECIP_100       = RecipW'(167773);

  localparam logic [ModeW-1:0] MODE_TICK      = 3'd0;
  localparam logic [ModeW-1:0] MODE_TAP       = 3'd1;
  localparam logic [ModeW-1:0] MODE_CHANGE    = 3'd2;
  localparam logic [ModeW-1:0] MODE_STOP      = 3'd3;
  localparam logic [ModeW-1:0] MODE_SET_TEMPO = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_RATE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_BUFFER_SIZE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPB,
    ST_POS,
    ST_INTV,
    ST_TEMPO,
    ST_DONE
  } ttbc_state_e;

  // Clamp a tempo value into the supported range of 1 to 999 beats per minute.
  function automatic logic [TempoW-1:0] sat_tempo(input logic [DivW-1:0] val);
    logic [TempoW-1:0] res;
    if (val < DivW'(TEMPO_MIN)) begin
      res = TEMPO_MIN;
    end else if (val > DivW'(TEMPO_MAX)) begin
      res = TEMPO_MAX;
    end else begin
      res = val[TempoW-1:0];
    end
    return res;
  endfunction

  // Saturated hundredth of a scaled rate. Values outside the tempo range are
  // clamped by compares; inside it a reciprocal multiplication does the divide.
  function automatic logic [TempoW-1:0] centi_to_tempo(input logic [DivW-1:0] val);
    logic [RecipProdW-1:0] prod;
    logic [TempoW-1:0]     res;
    prod = RecipProdW'(val[CentiW-1:0]) * RecipProdW'(RECIP_100);
    if (val < TEMPO_SCALE) begin
      res = TEMPO_MIN;
    end else if (val >= CENTI_TOP) begin
      res = TEMPO_MAX;
    end else begin
      res = prod[RECIP_SHIFT +: TempoW];
    end
    return res;
  endfunction

endpackage

// File: src/ttbc_div.sv
// ----------------------------------------------------------------------------
// Tap tempo beat clock divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by all steps.
// ----------------------------------------------------------------------------
module ttbc_div #(
  parameter int unsigned W = ttbc_pkg::DivW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CntW = (W > 1) ? $clog2(W) : 1;

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quot_q, quot_d;
  logic [W-1:0]    dvs_q;
  logic [W:0]      trial;
  logic [W:0]      diff;

  always_comb begin
    trial = {rem_q, quot_q[W-1]};
    diff  = trial - {1'b0, dvs_q};
    if (!diff[W]) begin
      rem_d  = diff[W-1:0];
      quot_d = {quot_q[W-2:0], 1'b1};
    end else begin
      rem_d  = trial[W-1:0];
      quot_d = {quot_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  `include "tap_tempo_beat_clock_core_assert.svh"

  `TTBC_ASSERT_IMPL(a_start_idle, start_i, !busy_q, "divider restarted mid-division")
  `TTBC_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "divider done held longer than a cycle")
  `TTBC_ASSERT_NEXT(a_busy_runs, busy_q && !start_i && (cnt_q != CntW'(W - 1)), busy_q,
                    "divider stopped before the last quotient bit")

endmodule

// File: src/tap_tempo_beat_clock_core.sv
// ----------------------------------------------------------------------------
// Tap tempo beat clock core
// A running tick takes two divisions on the shared divider, samples per beat
// and then the beat position; a measuring tap takes the mean interval and then
// the tempo. With a zero beat divisor or a zero tap interval one division is needed.
// Every other transaction needs no division; result stalls add to the time taken.
// Reset is asynchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module tap_tempo_beat_clock_core #(
  parameter int unsigned MAX_LOOP_BEATS = ttbc_pkg::MAX_LOOP_BEATS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ttbc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ttbc_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input transaction channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ttbc_pkg::ModeW-1:0]     mode_i,
  input  logic [ttbc_pkg::TapOffW-1:0]   tap_offset_i,
  input  logic [ttbc_pkg::TotInW-1:0]    loop_total_beats_i,
  input  logic [ttbc_pkg::BarW-1:0]      loop_bar_beats_i,
  input  logic [ttbc_pkg::TempoW-1:0]    tempo_value_i,
  // Result transaction channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           beat_start_o,
  output logic [ttbc_pkg::IdxW-1:0]      beat_index_o,
  output logic [ttbc_pkg::OffW-1:0]      beat_offset_o,
  output logic                           loop_restarted_o,
  output logic                           running_o,
  output logic [ttbc_pkg::TempoW-1:0]    tempo_now_o
);

  // Width of the stored loop length, enough to hold MAX_LOOP_BEATS itself.
  localparam int unsigned TotW = $clog2(MAX_LOOP_BEATS + 1);
  localparam int unsigned DivW = ttbc_pkg::DivW;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  ttbc_pkg::ttbc_state_e st_q, st_d;

  logic [ttbc_pkg::SrW-1:0]     sample_rate_q;
  logic [ttbc_pkg::BufW-1:0]    buffer_size_q;

  logic                         is_running_q;
  logic                         pending_valid_q;
  logic                         tap_active_q;
  logic [ttbc_pkg::TimeW-1:0]   position_q;
  logic [ttbc_pkg::TimeW-1:0]   sample_time_q;
  logic [ttbc_pkg::TimeW-1:0]   tap_first_q;
  logic [ttbc_pkg::TapCntW-1:0] tap_cnt_q;
  logic [ttbc_pkg::TempoW-1:0]  act_tempo_q;
  logic [ttbc_pkg::TempoW-1:0]  pend_tempo_q;
  logic [TotW-1:0]              act_tot_q;
  logic [ttbc_pkg::BarW-1:0]    act_bar_q;
  logic [TotW-1:0]              pend_tot_q;
  logic [ttbc_pkg::BarW-1:0]    pend_bar_q;
  logic [ttbc_pkg::SpbW-1:0]    spb_hold_q;

  // Beat fields of the transaction in flight, collected while it is worked on.
  logic                         r_bstart_q;
  logic [ttbc_pkg::IdxW-1:0]    r_bidx_q;
  logic [ttbc_pkg::OffW-1:0]    r_boff_q;
  logic                         r_restart_q;

  // Output register, which parts the result channel from the sequencer.
  logic                         out_valid_q;
  logic                         out_bstart_q;
  logic [ttbc_pkg::IdxW-1:0]    out_bidx_q;
  logic [ttbc_pkg::OffW-1:0]    out_boff_q;
  logic                         out_restart_q;
  logic                         out_running_q;
  logic [ttbc_pkg::TempoW-1:0]  out_tempo_q;

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  logic            div_start;
  logic [DivW-1:0] div_dividend;
  logic [DivW-1:0] div_divisor;
  logic            div_done;
  logic [DivW-1:0] div_quot;
  logic [DivW-1:0] div_rem;

  ttbc_div #(
    .W (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // --------------------------------------------------------------------------
  // Helper terms
  // --------------------------------------------------------------------------
  logic                         in_accept;
  logic                         out_free;
  logic                         out_load;
  logic                         tick_run;
  logic                         tap_measure;
  logic [ttbc_pkg::ProdW-1:0]   beat_prod;
  logic [ttbc_pkg::ProdW-3:0]   beat_div;
  logic [ttbc_pkg::TimeW-1:0]   tap_time;
  logic [ttbc_pkg::TapCntW-1:0] tap_cnt_n;
  logic [ttbc_pkg::SpbW-1:0]    spb_sel;
  logic [DivW-1:0]              tot_clamp;
  logic                         past_end;
  logic [ttbc_pkg::TimeW-1:0]   pos_base;
  logic [ttbc_pkg::TimeW-1:0]   buf_ext;
  logic [ttbc_pkg::TempoW-1:0]  tap_tempo;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (st_q == ttbc_pkg::ST_DONE) && out_free;

  assign tick_run    = (mode_i == ttbc_pkg::MODE_TICK) && is_running_q;
  assign tap_measure = (mode_i == ttbc_pkg::MODE_TAP) && tap_active_q &&
                       (tap_cnt_n != '0);

  // Beat divisor tempo*bar_beats/4; the quarter is a plain shift.
  assign beat_prod = ttbc_pkg::ProdW'(act_tempo_q) * ttbc_pkg::ProdW'(act_bar_q);
  assign beat_div  = beat_prod[ttbc_pkg::ProdW-1:2];

  assign tap_time  = sample_time_q + ttbc_pkg::TimeW'(tap_offset_i);
  assign tap_cnt_n = tap_cnt_q + ttbc_pkg::TapCntW'(1);
  assign buf_ext   = ttbc_pkg::TimeW'(buffer_size_q);

  // Tapped tempo: the scaled rate over the mean interval, then a hundredth of
  // it, taken by reciprocal multiplication and saturated to the tempo range.
  assign tap_tempo = ttbc_pkg::centi_to_tempo(div_quot);

  // A beat length that comes out as zero falls back to the last usable one.
  // The samples-per-beat quotient is always below 2^24, so the slice is exact.
  assign spb_sel = (div_quot == '0) ? spb_hold_q : div_quot[ttbc_pkg::SpbW-1:0];

  // Loop length saturates to 1..MAX_LOOP_BEATS.
  always_comb begin
    tot_clamp = DivW'(loop_total_beats_i);
    if (tot_clamp == '0) begin
      tot_clamp = DivW'(1);
    end else if (tot_clamp > DivW'(MAX_LOOP_BEATS)) begin
      tot_clamp = DivW'(MAX_LOOP_BEATS);
    end
  end

  // The beat index reaching or passing the loop length rewinds the loop.
  assign past_end = div_quot >= DivW'(act_tot_q);
  assign pos_base = past_end ? div_rem : position_q;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ttbc_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (tick_run) begin
            st_d = (beat_div != '0) ? ttbc_pkg::ST_SPB : ttbc_pkg::ST_POS;
          end else if (tap_measure) begin
            st_d = ttbc_pkg::ST_INTV;
          end else begin
            st_d = ttbc_pkg::ST_DONE;
          end
        end
      end
      ttbc_pkg::ST_SPB: begin
        if (div_done) begin
          st_d = ttbc_pkg::ST_POS;
        end
      end
      ttbc_pkg::ST_POS: begin
        if (div_done) begin
          st_d = ttbc_pkg::ST_DONE;
        end
      end
      ttbc_pkg::ST_INTV: begin
        if (div_done) begin
          st_d = (div_quot == '0) ? ttbc_pkg::ST_DONE : ttbc_pkg::ST_TEMPO;
        end
      end
      ttbc_pkg::ST_TEMPO: begin
        if (div_done) begin
          st_d = ttbc_pkg::ST_DONE;
        end
      end
      ttbc_pkg::ST_DONE: begin
        if (out_free) begin
          st_d = ttbc_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = ttbc_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs, which launch the divider with the next operands
  // --------------------------------------------------------------------------
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    in_stall_o   = (st_q != ttbc_pkg::ST_IDLE);
    unique case (st_q)
      ttbc_pkg::ST_IDLE: begin
        if (in_accept && tick_run) begin
          div_start = 1'b1;
          if (beat_div != '0) begin
            // Samples per beat from rate*60 over the beat divisor.
            div_dividend = DivW'(sample_rate_q) * ttbc_pkg::SEC_PER_MIN;
            div_divisor  = DivW'(beat_div);
          end else begin
            div_dividend = position_q;
            div_divisor  = DivW'(spb_hold_q);
          end
        end else if (in_accept && tap_measure) begin
          // Mean interval between the first click and this one.
          div_start    = 1'b1;
          div_dividend = tap_time - tap_first_q;
          div_divisor  = DivW'(tap_cnt_n);
        end
      end
      ttbc_pkg::ST_SPB: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = position_q;
          div_divisor  = DivW'(spb_sel);
        end
      end
      ttbc_pkg::ST_INTV: begin
        if (div_done && (div_quot != '0)) begin
          div_start    = 1'b1;
          div_dividend = DivW'(sample_rate_q) * ttbc_pkg::CENTI_SEC_PER_MIN;
          div_divisor  = div_quot;
        end
      end
      ttbc_pkg::ST_POS, ttbc_pkg::ST_TEMPO, ttbc_pkg::ST_DONE: begin
        div_start = 1'b0;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Control and beat clock state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q            <= ttbc_pkg::ST_IDLE;
      sample_rate_q   <= ttbc_pkg::SR_RESET;
      buffer_size_q   <= ttbc_pkg::BUF_RESET;
      is_running_q    <= 1'b0;
      pending_valid_q <= 1'b0;
      tap_active_q    <= 1'b0;
      position_q      <= '0;
      sample_time_q   <= '0;
      tap_first_q     <= '0;
      tap_cnt_q       <= '0;
      act_tempo_q     <= ttbc_pkg::TEMPO_RESET;
      pend_tempo_q    <= ttbc_pkg::TEMPO_RESET;
      act_tot_q       <= TotW'(1);
      act_bar_q       <= ttbc_pkg::BAR_RESET;
      pend_tot_q      <= TotW'(1);
      pend_bar_q      <= ttbc_pkg::BAR_RESET;
      spb_hold_q      <= ttbc_pkg::SPB_RESET;
      r_bstart_q      <= 1'b0;
      r_bidx_q        <= '0;
      r_boff_q        <= '0;
      r_restart_q     <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      st_q <= st_d;

      // The user must issue configuration writes only while the block is idle; it is not enforced.
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          ttbc_pkg::CFG_SAMPLE_RATE: sample_rate_q <= cfg_data_i[ttbc_pkg::SrW-1:0];
          ttbc_pkg::CFG_BUFFER_SIZE: buffer_size_q <= cfg_data_i[ttbc_pkg::BufW-1:0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        ttbc_pkg::ST_IDLE: begin
          if (in_accept) begin
            r_bstart_q  <= 1'b0;
            r_bidx_q    <= '0;
            r_boff_q    <= '0;
            r_restart_q <= 1'b0;
            unique case (mode_i)
              ttbc_pkg::MODE_TICK: begin
                sample_time_q <= sample_time_q + buf_ext;
              end
              ttbc_pkg::MODE_TAP: begin
                if (!tap_active_q) begin
                  // First click opens a measurement.
                  tap_first_q  <= tap_time;
                  tap_cnt_q    <= '0;
                  tap_active_q <= 1'b1;
                end else begin
                  tap_cnt_q <= tap_cnt_n;
                  if (tap_cnt_n >= ttbc_pkg::TAP_LAST) begin
                    tap_active_q <= 1'b0;
                  end
                end
              end
              ttbc_pkg::MODE_CHANGE: begin
                pend_tot_q      <= TotW'(tot_clamp);
                pend_bar_q      <= loop_bar_beats_i;
                pending_valid_q <= 1'b1;
                // An idle clock starts at once on the new loop.
                if (!is_running_q) begin
                  act_tempo_q  <= pend_tempo_q;
                  act_tot_q    <= TotW'(tot_clamp);
                  act_bar_q    <= loop_bar_beats_i;
                  position_q   <= '0;
                  is_running_q <= 1'b1;
                end
              end
              ttbc_pkg::MODE_STOP: begin
                pending_valid_q <= 1'b0;
              end
              ttbc_pkg::MODE_SET_TEMPO: begin
                pend_tempo_q <= ttbc_pkg::sat_tempo(DivW'(tempo_value_i));
              end
              default: begin
              end
            endcase
          end
        end
        ttbc_pkg::ST_SPB: begin
          if (div_done) begin
            spb_hold_q <= spb_sel;
          end
        end
        ttbc_pkg::ST_POS: begin
          if (div_done) begin
            if (past_end) begin
              // Loop end: rewind and take the pending tempo; take the pending loop if one is set, else stop.
              act_tempo_q <= pend_tempo_q;
              if (pending_valid_q) begin
                act_tot_q   <= pend_tot_q;
                act_bar_q   <= pend_bar_q;
                r_restart_q <= 1'b1;
              end else begin
                is_running_q <= 1'b0;
              end
            end
            if (!past_end || pending_valid_q) begin
              r_bidx_q   <= past_end ? '0 : div_quot[ttbc_pkg::IdxW-1:0];
              position_q <= pos_base + buf_ext;
              if (div_rem < buf_ext) begin
                r_bstart_q <= 1'b1;
                r_boff_q   <= div_rem[ttbc_pkg::OffW-1:0];
              end
            end else begin
              position_q <= div_rem;
            end
          end
        end
        ttbc_pkg::ST_TEMPO: begin
          if (div_done) begin
            act_tempo_q  <= tap_tempo;
            pend_tempo_q <= tap_tempo;
          end
        end
        ttbc_pkg::ST_INTV, ttbc_pkg::ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result payload: loaded once all state of the transaction has settled.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bstart_q  <= r_bstart_q;
      out_bidx_q    <= r_bidx_q;
      out_boff_q    <= r_boff_q;
      out_restart_q <= r_restart_q;
      out_running_q <= is_running_q;
      out_tempo_q   <= act_tempo_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign beat_start_o     = out_bstart_q;
  assign beat_index_o     = out_bidx_q;
  assign beat_offset_o    = out_boff_q;
  assign loop_restarted_o = out_restart_q;
  assign running_o        = out_running_q;
  assign tempo_now_o      = out_tempo_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `include "tap_tempo_beat_clock_core_assert.svh"

  `TTBC_ASSERT_IMPL(a_div_done_state, div_done,
                    (st_q == ttbc_pkg::ST_SPB) || (st_q == ttbc_pkg::ST_POS) ||
                    (st_q == ttbc_pkg::ST_INTV) || (st_q == ttbc_pkg::ST_TEMPO),
                    "divider finished outside a division step")
  `TTBC_ASSERT_IMPL(a_tap_cnt_range, 1'b1, tap_cnt_q <= ttbc_pkg::TAP_LAST,
                    "tap count beyond the last click")
  `TTBC_ASSERT_IMPL(a_restart_running, out_valid_q && (out_restart_q || out_bstart_q),
                    out_running_q, "beat reported while the clock is stopped")
  `TTBC_ASSERT_NEXT(a_done_to_idle, out_load, st_q == ttbc_pkg::ST_IDLE,
                    "sequencer did not return to idle after loading a result")

endmodule
